### hw/rtl/aict_pkg.sv
// Shared types, constants and helpers for the ACL in-flight credit tracker.
package aict_pkg;

	localparam int TRACK_DEPTH_DEF = 8;
	localparam int OP_W            = 3;
	localparam int HANDLE_W        = 12;
	localparam int COUNT_W         = 16;
	localparam int STATUS_W        = 8;
	localparam int LIMIT_W         = 16;

	localparam logic [OP_W-1:0] OP_CHECK = 3'd0;
	localparam logic [OP_W-1:0] OP_SENT  = 3'd1;
	localparam logic [OP_W-1:0] OP_DONE  = 3'd2;
	localparam logic [OP_W-1:0] OP_DISC  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  done_count;
		logic [STATUS_W-1:0] disc_status;
	} in_word_t;

	typedef struct packed {
		logic               at_limit;
		logic [COUNT_W-1:0] link_outstanding;
		logic [COUNT_W-1:0] total_outstanding;
		logic [COUNT_W-1:0] overflow_count;
	} out_word_t;

	// One row of the link table.
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
	} entry_t;

	// Increment that sticks at the top of the range.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage

### hw/rtl/aict_mem.sv
// Link table memory: one write port, one read port, registered read data.
module aict_mem import aict_pkg::*; #(
	parameter int DEPTH = TRACK_DEPTH_DEF,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/aict_engine.sv
// Operation sequencer: handle search, read-modify-write of the link table, counters.
module aict_engine import aict_pkg::*; #(
	parameter int TRACK_DEPTH = TRACK_DEPTH_DEF,
	parameter int IDX_W       = 3,
	parameter int CNT_W       = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] acl_limit,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               res_valid,
	output out_word_t          res_word,
	input  logic               res_take,
	output logic               mem_we,
	output logic [IDX_W-1:0]   mem_waddr,
	output entry_t             mem_wdata,
	output logic               mem_re,
	output logic [IDX_W-1:0]   mem_raddr,
	input  entry_t             mem_rdata
);

	typedef enum logic [2:0] {ST_IDLE, ST_SEARCH, ST_UPDATE, ST_MOVE, ST_EMIT} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [HANDLE_W-1:0] hdl_q;
	logic [COUNT_W-1:0]  done_q;
	logic [STATUS_W-1:0] stat_q;
	logic [CNT_W-1:0]    iss_q;
	logic                pend_q;
	logic [IDX_W-1:0]    rdi_q;
	logic                found_q;
	logic [IDX_W-1:0]    slot_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]    used_q;
	logic [COUNT_W-1:0]  total_q;
	logic [COUNT_W-1:0]  ovf_q;
	out_word_t           res_q;

	logic               hit;
	logic               room;
	logic               more;
	logic [CNT_W-1:0]   last_cnt;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   used_idx;
	logic [COUNT_W-1:0] freed;

	logic [COUNT_W-1:0] u_total;
	logic [CNT_W-1:0]   u_used;
	logic [COUNT_W-1:0] u_ovf;
	logic               u_at;
	logic [COUNT_W-1:0] u_link;
	logic               u_we;
	logic [IDX_W-1:0]   u_waddr;
	entry_t             u_wdata;
	logic               u_move;

	assign hit      = pend_q && (mem_rdata.handle == hdl_q);
	assign room     = used_q < CNT_W'(TRACK_DEPTH);
	assign more     = iss_q < used_q;
	assign last_cnt = used_q - CNT_W'(1);
	assign last_idx = last_cnt[IDX_W-1:0];
	assign used_idx = used_q[IDX_W-1:0];
	assign freed    = (cnt_q < done_q) ? cnt_q : done_q;

	always_comb begin
		u_total = total_q;
		u_used  = used_q;
		u_ovf   = ovf_q;
		u_at    = 1'b0;
		u_link  = found_q ? cnt_q : '0;
		u_we    = 1'b0;
		u_waddr = slot_q;
		u_wdata = '{handle: hdl_q, count: cnt_q};
		u_move  = 1'b0;
		unique case (op_q)
			OP_CHECK: begin
				if (acl_limit != '0) begin
					if (found_q) begin
						u_at = total_q >= acl_limit;
					end else if (room) begin
						u_we    = 1'b1;
						u_waddr = used_idx;
						u_wdata = '{handle: hdl_q, count: '0};
						u_used  = used_q + CNT_W'(1);
						u_at    = total_q >= acl_limit;
						u_link  = '0;
					end else begin
						u_ovf = sat_inc(ovf_q);
					end
				end
			end
			OP_SENT: begin
				if (found_q) begin
					u_link  = sat_inc(cnt_q);
					u_we    = 1'b1;
					u_wdata = '{handle: hdl_q, count: sat_inc(cnt_q)};
					u_total = sat_inc(total_q);
				end else if (room) begin
					u_we    = 1'b1;
					u_waddr = used_idx;
					u_wdata = '{handle: hdl_q, count: COUNT_W'(1)};
					u_used  = used_q + CNT_W'(1);
					u_total = sat_inc(total_q);
					u_link  = COUNT_W'(1);
				end else begin
					u_ovf = sat_inc(ovf_q);
				end
			end
			OP_DONE: begin
				if (found_q) begin
					u_link  = cnt_q - freed;
					u_we    = 1'b1;
					u_wdata = '{handle: hdl_q, count: cnt_q - freed};
					u_total = (total_q > freed) ? total_q - freed : '0;
				end
			end
			OP_DISC: begin
				if (stat_q == '0 && found_q) begin
					u_total = (total_q > cnt_q) ? total_q - cnt_q : '0;
					u_used  = last_cnt;
					u_link  = '0;
					u_move  = slot_q != last_idx;
				end
			end
			OP_CLEAR: begin
				u_used  = '0;
				u_total = '0;
				u_link  = '0;
			end
			default: begin
			end
		endcase
	end

	// Reads walk the table during the search; a removal reads the last row to move it.
	assign mem_re    = (state_q == ST_SEARCH && !hit && more) ||
	                   (state_q == ST_UPDATE && u_move);
	assign mem_raddr = (state_q == ST_SEARCH) ? iss_q[IDX_W-1:0] : last_idx;
	assign mem_we    = (state_q == ST_UPDATE && u_we) || (state_q == ST_MOVE);
	assign mem_waddr = (state_q == ST_MOVE) ? slot_q : u_waddr;
	assign mem_wdata = (state_q == ST_MOVE) ? mem_rdata : u_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= '0;
			hdl_q   <= '0;
			done_q  <= '0;
			stat_q  <= '0;
			iss_q   <= '0;
			pend_q  <= 1'b0;
			rdi_q   <= '0;
			found_q <= 1'b0;
			slot_q  <= '0;
			cnt_q   <= '0;
			used_q  <= '0;
			total_q <= '0;
			ovf_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= in_word.operation;
						hdl_q   <= in_word.handle;
						done_q  <= in_word.done_count;
						stat_q  <= in_word.disc_status;
						iss_q   <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						state_q <= (in_word.operation == OP_CLEAR) ? ST_UPDATE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
						slot_q  <= rdi_q;
						cnt_q   <= mem_rdata.count;
						pend_q  <= 1'b0;
						state_q <= ST_UPDATE;
					end else if (more) begin
						pend_q <= 1'b1;
						rdi_q  <= iss_q[IDX_W-1:0];
						iss_q  <= iss_q + CNT_W'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					total_q <= u_total;
					used_q  <= u_used;
					ovf_q   <= u_ovf;
					res_q   <= '{at_limit: u_at, link_outstanding: u_link,
					             total_outstanding: u_total, overflow_count: u_ovf};
					state_q <= u_move ? ST_MOVE : ST_EMIT;
				end
				ST_MOVE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign res_valid = state_q == ST_EMIT;
	assign res_word  = res_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TRACK_DEPTH))
		else $error("table fill count beyond depth");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_UPDATE || state_q == ST_MOVE))
		else $error("table written outside the update phase");

	a_move_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE |-> $past(mem_re))
		else $error("row move without a preceding read of the last row");

	a_limit_only_check: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.at_limit) |-> (op_q == OP_CHECK && acl_limit != '0))
		else $error("at_limit raised by an operation other than check");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> iss_q <= used_q)
		else $error("search ran past the filled part of the table");

endmodule

### hw/rtl/acl_inflight_credit_tracker.sv
// Top level of the ACL in-flight credit tracker: limit register, output register, wiring.
//
//   channel  direction  handshake               word
//   cfg      in         cfg_valid / cfg_ready   cfg_data   (acl_limit, 16 bits)
//   in       in         in_valid  / in_stall    in_word    (one operation)
//   out      out        out_valid / out_stall   out_word   (one result per operation)
//
// Each operation leaves the input stalled from acceptance until its result has been
// handed to the output register. The gap from one accepted word to the next is
// shortest for a clear, which skips the search, and longest for a miss in a full
// table. The gap is set by the handle search, which reads one table row per cycle
// through the single read port of the link table memory; a successful disconnect of a
// row other than the last adds a move state that copies the last row into its place.
// Reset (arst_n low, asynchronous) empties the table, zeroes the total, the overflow
// count and the limit; the table rows themselves are not cleared, as only rows below
// the fill count are ever read. While out_stall holds a result in the output register,
// the next result waits in the sequencer and no new word is taken.
module acl_inflight_credit_tracker import aict_pkg::*; #(
	parameter int TRACK_DEPTH = TRACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word
);

	// Row index width, and the width of a count that can hold the depth itself.
	localparam int IDX_W = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(TRACK_DEPTH + 1);

	logic [LIMIT_W-1:0] limit_q;
	logic               out_valid_q;
	out_word_t          out_word_q;

	logic             res_valid;
	out_word_t        res_word;
	logic             res_take;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	// Always ready; the user ensures the limit register is changed only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// The sequencer owns all table state and the running counters; every access to a
	// row is finished before the next operation is accepted, so no two accesses to the
	// same row overlap and no forwarding is needed.
	aict_engine #(
		.TRACK_DEPTH (TRACK_DEPTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.acl_limit (limit_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.res_valid (res_valid),
		.res_word  (res_word),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	aict_mem #(
		.DEPTH (TRACK_DEPTH),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register loads a result when it is empty or is being emptied this
	// cycle, so the sequencer can return to idle while the previous word waits.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_word_q <= res_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
